// ===== hw/rtl/lidar_bev_voxel_accumulator_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the BEV voxel accumulator
// Implication checks on the core clock, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LIDAR_BEV_VOXEL_ACCUMULATOR_CORE_MACROS_SVH
`define LIDAR_BEV_VOXEL_ACCUMULATOR_CORE_MACROS_SVH

// same-cycle implication
`define LBVA_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define LBVA_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== hw/rtl/lbva_pkg.sv =====
// ----------------------------------------------------------------------------
// lbva_pkg
// Shared types, constants and index helpers of the BEV voxel accumulator.
// ----------------------------------------------------------------------------
package lbva_pkg;

   localparam int GRID_COLS_DEF     = 300;
   localparam int GRID_ROWS_DEF     = 300;
   localparam int HEIGHT_SLICES_DEF = 60;
   localparam int COUNT_BITS_DEF    = 20;

   localparam int XY_MIN_MM  = -75000;
   localparam int Z_MIN_MM   = -2000;
   localparam int XY_STEP_MM = 500;
   localparam int Z_STEP_MM  = 100;

   localparam int ACT_W  = 2;
   localparam int XY_W   = 18;
   localparam int Z_W    = 14;
   localparam int VAL_W  = 16;
   localparam int NXY_W  = 19;   // x - min inside the box, < 1024*500
   localparam int NZ_W   = 13;   // z - min inside the box, < 64*100
   localparam int QXY_W  = 10;
   localparam int QZ_W   = 7;

   // reciprocal scaling: q ~ (n * RCP) >> SHIFT, low by at most one
   localparam int XY_SHIFT = 28;
   localparam int XY_RCP   = (1 << XY_SHIFT) / XY_STEP_MM;
   localparam int Z_SHIFT  = 24;
   localparam int Z_RCP    = (1 << Z_SHIFT) / Z_STEP_MM;

   localparam int DIV_STEPS = VAL_W;  // mean always fits 16 bits
   localparam int DIV_CNT_W = 4;

   typedef enum logic [ACT_W-1:0] {
      ACT_ADD        = 2'd0,
      ACT_READ       = 2'd1,
      ACT_READ_CLEAR = 2'd2,
      ACT_NONE       = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_PREP, ST_SCALE, ST_INDEX,
      ST_ADDR, ST_READ, ST_UPDATE, ST_DIVIDE, ST_DONE
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic prep;
      logic scale;
      logic index;
      logic addr;
      logic read;
      logic update;
      logic div_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic div_last;
      logic out_free;
   } status_type;

   function automatic logic [QXY_W-1:0] fix_xy(logic [NXY_W-1:0] n, logic [QXY_W-1:0] e);
      logic [NXY_W:0] r;
      r = {1'b0, n} - (NXY_W+1)'(e) * (NXY_W+1)'(XY_STEP_MM);
      return (r >= (NXY_W+1)'(XY_STEP_MM)) ? e + QXY_W'(1) : e;
   endfunction

   function automatic logic [QZ_W-1:0] fix_z(logic [NZ_W-1:0] n, logic [QZ_W-1:0] e);
      logic [NZ_W:0] r;
      r = {1'b0, n} - (NZ_W+1)'(e) * (NZ_W+1)'(Z_STEP_MM);
      return (r >= (NZ_W+1)'(Z_STEP_MM)) ? e + QZ_W'(1) : e;
   endfunction

endpackage

// ===== hw/rtl/lbva_ctrl.sv =====
// ----------------------------------------------------------------------------
// lbva_ctrl
// Sequencer: clearing sweep, then one transaction at a time through the datapath.
// ----------------------------------------------------------------------------
module lbva_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  lbva_pkg::status_type  status,
   output lbva_pkg::cmd_type     cmd
);

   lbva_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lbva_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         lbva_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) state_in = lbva_pkg::ST_IDLE;
         end
         lbva_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = lbva_pkg::ST_PREP;
            end
         end
         lbva_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = lbva_pkg::ST_SCALE;
         end
         lbva_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = lbva_pkg::ST_INDEX;
         end
         lbva_pkg::ST_INDEX: begin
            cmd.index = 1'b1;
            state_in  = lbva_pkg::ST_ADDR;
         end
         lbva_pkg::ST_ADDR: begin
            cmd.addr = 1'b1;
            state_in = lbva_pkg::ST_READ;
         end
         lbva_pkg::ST_READ: begin
            cmd.read = 1'b1;
            state_in = lbva_pkg::ST_UPDATE;
         end
         lbva_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = lbva_pkg::ST_DIVIDE;
         end
         lbva_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = lbva_pkg::ST_DONE;
         end
         lbva_pkg::ST_DONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = lbva_pkg::ST_IDLE;
            end
         end
         default: state_in = lbva_pkg::ST_CLEAR;
      endcase
   end

endmodule

// ===== hw/rtl/lbva_datapath.sv =====
// ----------------------------------------------------------------------------
// lbva_datapath
// Cell indexing, cell store read-modify-write, mean dividers, output register.
// ----------------------------------------------------------------------------
module lbva_datapath #(
   parameter int GRID_COLS     = lbva_pkg::GRID_COLS_DEF,
   parameter int GRID_ROWS     = lbva_pkg::GRID_ROWS_DEF,
   parameter int HEIGHT_SLICES = lbva_pkg::HEIGHT_SLICES_DEF,
   parameter int COUNT_BITS    = lbva_pkg::COUNT_BITS_DEF,
   parameter int ROW_W         = $clog2(GRID_ROWS),
   parameter int COL_W         = $clog2(GRID_COLS),
   parameter int REQ_W         = 104,
   parameter int RSP_W         = 136
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lbva_pkg::cmd_type           cmd,
   output lbva_pkg::status_type        status,
   input  logic [REQ_W-1:0]            req_tdata,
   input  logic [lbva_pkg::ACT_W-1:0]  req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [RSP_W-1:0]            rsp_tdata
);

   localparam int CELLS  = GRID_ROWS * GRID_COLS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int SL_W   = (HEIGHT_SLICES > 1) ? $clog2(HEIGHT_SLICES) : 1;
   localparam int SUM_W  = lbva_pkg::VAL_W + COUNT_BITS;
   localparam int ENT_W  = HEIGHT_SLICES + 2 * SUM_W + COUNT_BITS;
   localparam int VW     = lbva_pkg::VAL_W;
   localparam int RSP_BITS = 1 + ROW_W + COL_W + HEIGHT_SLICES + 2 * VW + COUNT_BITS;

   localparam logic signed [19:0] X_LO = 20'(lbva_pkg::XY_MIN_MM);
   localparam logic signed [19:0] X_HI =
      20'(lbva_pkg::XY_MIN_MM + GRID_COLS * lbva_pkg::XY_STEP_MM);
   localparam logic signed [19:0] Y_HI =
      20'(lbva_pkg::XY_MIN_MM + GRID_ROWS * lbva_pkg::XY_STEP_MM);
   localparam logic signed [15:0] Z_LO = 16'(lbva_pkg::Z_MIN_MM);
   localparam logic signed [15:0] Z_HI =
      16'(lbva_pkg::Z_MIN_MM + HEIGHT_SLICES * lbva_pkg::Z_STEP_MM);

   // captured request
   lbva_pkg::action_type           act_ff;
   logic [lbva_pkg::XY_W-1:0]      px_ff, py_ff;
   logic [lbva_pkg::Z_W-1:0]       pz_ff;
   logic [VW-1:0]                  int_ff, elo_ff;
   logic [ROW_W-1:0]               qrow_ff;
   logic [COL_W-1:0]               qcol_ff;

   // index pipeline
   logic signed [19:0]             sx, sy;
   logic signed [15:0]             sz;
   logic                           inbox_ff;
   logic [lbva_pkg::NXY_W-1:0]     nx_ff, ny_ff;
   logic [lbva_pkg::NZ_W-1:0]      nz_ff;
   logic [38:0]                    prod_x, prod_y;
   logic [30:0]                    prod_z;
   logic [lbva_pkg::QXY_W-1:0]     ex_ff, ey_ff, fx, fy;
   logic [lbva_pkg::QZ_W-1:0]      ez_ff, fz;
   logic [ROW_W-1:0]               row_ff, hit_row_ff;
   logic [COL_W-1:0]               col_ff, hit_col_ff;
   logic [SL_W-1:0]                slice_ff;
   logic                           valid_ff;
   logic [ADDR_W-1:0]              addr_ff;

   // cell store
   logic [ENT_W-1:0]               mem [CELLS];
   logic [ENT_W-1:0]               rd_ff, wr_data;
   logic [ADDR_W-1:0]              wr_addr, clr_addr_ff;
   logic                           wr_en;

   // update
   logic [HEIGHT_SLICES-1:0]       old_occ, rep_occ_in, rep_occ_ff;
   logic [SUM_W-1:0]               old_isum, old_esum, new_isum, new_esum;
   logic [SUM_W-1:0]               rep_isum_in, rep_esum_in;
   logic [COUNT_BITS-1:0]          old_cnt, rep_cnt_in, rep_cnt_ff;
   logic                           do_add, acc_ff;

   // dividers
   logic [COUNT_BITS-1:0]          irem_ff, erem_ff, irem_in, erem_in;
   logic [VW-1:0]                  iq_ff, eq_ff;
   logic                           ige, ege;
   logic [lbva_pkg::DIV_CNT_W-1:0] div_cnt_ff;

   // output register
   logic                           rsp_valid_ff;
   logic [RSP_W-1:0]               rsp_data_ff;
   logic [RSP_BITS-1:0]            rsp_pack;

   assign sx = {{2{px_ff[lbva_pkg::XY_W-1]}}, px_ff};
   assign sy = {{2{py_ff[lbva_pkg::XY_W-1]}}, py_ff};
   assign sz = {{2{pz_ff[lbva_pkg::Z_W-1]}}, pz_ff};

   assign prod_x = 39'(nx_ff) * 39'(lbva_pkg::XY_RCP);
   assign prod_y = 39'(ny_ff) * 39'(lbva_pkg::XY_RCP);
   assign prod_z = 31'(nz_ff) * 31'(lbva_pkg::Z_RCP);
   assign fx = lbva_pkg::fix_xy(nx_ff, ex_ff);
   assign fy = lbva_pkg::fix_xy(ny_ff, ey_ff);
   assign fz = lbva_pkg::fix_z(nz_ff, ez_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff  <= lbva_pkg::action_type'(req_tuser);
         px_ff   <= req_tdata[17:0];
         py_ff   <= req_tdata[35:18];
         pz_ff   <= req_tdata[49:36];
         int_ff  <= req_tdata[65:50];
         elo_ff  <= req_tdata[81:66];
         qrow_ff <= req_tdata[82 +: ROW_W];
         qcol_ff <= req_tdata[82 + ROW_W +: COL_W];
      end
      if (cmd.prep) begin
         inbox_ff <= (sx > X_LO) && (sx < X_HI) && (sy > X_LO) && (sy < Y_HI) &&
                     (sz > Z_LO) && (sz < Z_HI);
         nx_ff    <= lbva_pkg::NXY_W'(sx - X_LO);
         ny_ff    <= lbva_pkg::NXY_W'(sy - X_LO);
         nz_ff    <= lbva_pkg::NZ_W'(sz - Z_LO);
      end
      if (cmd.scale) begin
         ex_ff <= prod_x[lbva_pkg::XY_SHIFT +: lbva_pkg::QXY_W];
         ey_ff <= prod_y[lbva_pkg::XY_SHIFT +: lbva_pkg::QXY_W];
         ez_ff <= prod_z[lbva_pkg::Z_SHIFT +: lbva_pkg::QZ_W];
      end
      if (cmd.index) begin
         slice_ff <= SL_W'(fz);
         case (act_ff)
            lbva_pkg::ACT_ADD: begin
               row_ff     <= ROW_W'(fy);
               col_ff     <= COL_W'(fx);
               valid_ff   <= inbox_ff;
               hit_row_ff <= inbox_ff ? ROW_W'(fy) : '0;
               hit_col_ff <= inbox_ff ? COL_W'(fx) : '0;
            end
            lbva_pkg::ACT_READ, lbva_pkg::ACT_READ_CLEAR: begin
               row_ff     <= qrow_ff;
               col_ff     <= qcol_ff;
               valid_ff   <= (32'(qrow_ff) < GRID_ROWS) && (32'(qcol_ff) < GRID_COLS);
               hit_row_ff <= qrow_ff;
               hit_col_ff <= qcol_ff;
            end
            default: begin
               row_ff     <= '0;
               col_ff     <= '0;
               valid_ff   <= 1'b0;
               hit_row_ff <= '0;
               hit_col_ff <= '0;
            end
         endcase
      end
      if (cmd.addr) begin
         addr_ff <= ADDR_W'(32'(row_ff) * GRID_COLS + 32'(col_ff));
      end
   end

   // cell store: single write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (cmd.read) rd_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
      end
   end

   // entry layout from low bits: count, elongation sum, intensity sum, occupancy
   assign old_cnt  = rd_ff[0 +: COUNT_BITS];
   assign old_esum = rd_ff[COUNT_BITS +: SUM_W];
   assign old_isum = rd_ff[COUNT_BITS + SUM_W +: SUM_W];
   assign old_occ  = rd_ff[COUNT_BITS + 2 * SUM_W +: HEIGHT_SLICES];
   assign new_isum = old_isum + SUM_W'(int_ff);
   assign new_esum = old_esum + SUM_W'(elo_ff);

   always_comb begin
      do_add      = (act_ff == lbva_pkg::ACT_ADD) && valid_ff && (old_cnt != '1);
      rep_occ_in  = '0;
      rep_isum_in = '0;
      rep_esum_in = '0;
      rep_cnt_in  = '0;
      if (do_add) begin
         rep_occ_in  = old_occ | (HEIGHT_SLICES'(1) << slice_ff);
         rep_isum_in = new_isum;
         rep_esum_in = new_esum;
         rep_cnt_in  = old_cnt + COUNT_BITS'(1);
      end else if (valid_ff) begin
         rep_occ_in  = old_occ;
         rep_isum_in = old_isum;
         rep_esum_in = old_esum;
         rep_cnt_in  = old_cnt;
      end
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = '0;
      if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
      end else if (cmd.update && do_add) begin
         wr_en   = 1'b1;
         wr_data = {rep_occ_in, rep_isum_in, rep_esum_in, rep_cnt_in};
      end else if (cmd.update && valid_ff && act_ff == lbva_pkg::ACT_READ_CLEAR) begin
         wr_en = 1'b1;
      end
   end

   // restoring dividers; sum < count * 2^16 so the top bits start below count
   always_comb begin
      ige     = {irem_ff, iq_ff[VW-1]} >= (COUNT_BITS+1)'(rep_cnt_ff);
      ege     = {erem_ff, eq_ff[VW-1]} >= (COUNT_BITS+1)'(rep_cnt_ff);
      irem_in = ige ? COUNT_BITS'({irem_ff, iq_ff[VW-1]} - (COUNT_BITS+1)'(rep_cnt_ff))
                    : {irem_ff[COUNT_BITS-2:0], iq_ff[VW-1]};
      erem_in = ege ? COUNT_BITS'({erem_ff, eq_ff[VW-1]} - (COUNT_BITS+1)'(rep_cnt_ff))
                    : {erem_ff[COUNT_BITS-2:0], eq_ff[VW-1]};
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         acc_ff     <= do_add;
         rep_occ_ff <= rep_occ_in;
         rep_cnt_ff <= rep_cnt_in;
         irem_ff    <= rep_isum_in[SUM_W-1 -: COUNT_BITS];
         erem_ff    <= rep_esum_in[SUM_W-1 -: COUNT_BITS];
         iq_ff      <= rep_isum_in[VW-1:0];
         eq_ff      <= rep_esum_in[VW-1:0];
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         irem_ff    <= irem_in;
         erem_ff    <= erem_in;
         iq_ff      <= {iq_ff[VW-2:0], ige};
         eq_ff      <= {eq_ff[VW-2:0], ege};
         div_cnt_ff <= div_cnt_ff + lbva_pkg::DIV_CNT_W'(1);
      end
   end

   assign rsp_pack = {rep_cnt_ff,
                      (rep_cnt_ff == '0) ? VW'(0) : eq_ff,
                      (rep_cnt_ff == '0) ? VW'(0) : iq_ff,
                      rep_occ_ff, hit_col_ff, hit_row_ff, acc_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) rsp_data_ff <= RSP_W'(rsp_pack);
   end

   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_tdata         = rsp_data_ff;
   assign status.clear_last = (32'(clr_addr_ff) == CELLS - 1);
   assign status.div_last   = (div_cnt_ff == lbva_pkg::DIV_CNT_W'(lbva_pkg::DIV_STEPS - 1));
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

endmodule

// ===== hw/rtl/lidar_bev_voxel_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// lidar_bev_voxel_accumulator_core
// Bird's-eye-view voxel grid: accumulates lidar points per cell, reads means.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | content
//  req_    | in  | tvalid/tready      | tuser: action; tdata: point and cell fields
//  rsp_    | out | tvalid/tready      | tdata: one result per request transaction
//
//  Each transaction runs PREP, SCALE, INDEX and ADDR for coordinate scaling and
//  addressing, READ for the store read, UPDATE for the update/write, DIVIDE for
//  the two radix-2 mean dividers and DONE to load the output register. The next
//  request is taken only after DONE, one transaction at a time; DONE waits while
//  the output register still holds a result that has not been taken.
//  After reset a clearing sweep writes every cell, GRID_ROWS*GRID_COLS of them
//  (90000 at default); req_tready stays low until it ends.
//  A finished result sits in the output register; the next request is taken
//  meanwhile, and only its own result waits for rsp_tready.
// ----------------------------------------------------------------------------
`include "lidar_bev_voxel_accumulator_core_macros.svh"

module lidar_bev_voxel_accumulator_core #(
   parameter int GRID_COLS     = lbva_pkg::GRID_COLS_DEF,
   parameter int GRID_ROWS     = lbva_pkg::GRID_ROWS_DEF,
   parameter int HEIGHT_SLICES = lbva_pkg::HEIGHT_SLICES_DEF,
   parameter int COUNT_BITS    = lbva_pkg::COUNT_BITS_DEF,
   // derived, not meant to be overridden
   parameter int ROW_W = $clog2(GRID_ROWS),
   parameter int COL_W = $clog2(GRID_COLS),
   parameter int REQ_W = ((82 + ROW_W + COL_W + 7) / 8) * 8,
   parameter int RSP_W =
      ((1 + ROW_W + COL_W + HEIGHT_SLICES + 32 + COUNT_BITS + 7) / 8) * 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // low to high: point_x 18, point_y 18, point_z 14, intensity 16,
   // elongation 16, cell_row, cell_col, zero fill
   input  logic [REQ_W-1:0]            req_tdata,
   // action
   input  logic [lbva_pkg::ACT_W-1:0]  req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // low to high: accepted, hit_row, hit_col, occupancy, mean_intensity,
   // mean_elongation, point_count, zero fill
   output logic [RSP_W-1:0]            rsp_tdata
);

   localparam int OCC_LO = 1 + ROW_W + COL_W;
   localparam int MI_LO  = OCC_LO + HEIGHT_SLICES;
   localparam int ME_LO  = MI_LO + lbva_pkg::VAL_W;
   localparam int CNT_LO = ME_LO + lbva_pkg::VAL_W;

   lbva_pkg::cmd_type    cmd;
   lbva_pkg::status_type status;

   // result fields watched by the checks below
   logic                  rsp_acc;
   logic [COUNT_BITS-1:0] rsp_cnt;
   logic [31:0]           rsp_means;

   // controller owns sequencing and the input handshake
   lbva_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath owns the cell store, dividers and the output register
   lbva_datapath #(
      .GRID_COLS     (GRID_COLS),
      .GRID_ROWS     (GRID_ROWS),
      .HEIGHT_SLICES (HEIGHT_SLICES),
      .COUNT_BITS    (COUNT_BITS),
      .ROW_W         (ROW_W),
      .COL_W         (COL_W),
      .REQ_W         (REQ_W),
      .RSP_W         (RSP_W)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   assign rsp_acc   = rsp_tdata[0];
   assign rsp_cnt   = rsp_tdata[CNT_LO +: COUNT_BITS];
   assign rsp_means = rsp_tdata[MI_LO +: 32];

   // no request taken while the store is being swept
   `LBVA_ASSERT_NOW(a_no_req_in_sweep, cmd.clear_step, !req_tready, "request during sweep")
   // one transaction in flight: accepting closes the input next cycle
   `LBVA_ASSERT_NEXT(a_single_flight, req_tvalid && req_tready, !req_tready, "overlap")
   // a counted point always leaves a nonzero count
   `LBVA_ASSERT_NOW(a_acc_count, rsp_tvalid && rsp_acc, rsp_cnt != '0, "accepted, zero count")
   // an empty cell reports zero means
   `LBVA_ASSERT_NOW(a_empty_means, rsp_tvalid && rsp_cnt == '0, rsp_means == '0, "nonzero mean")

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the BEV voxel accumulator core. A directed table of
// boundary points, reads and clears is followed by random traffic concentrated
// on a few hot cells. A grid model predicts each unpinned response. Both stream
// sides idle at random, with one long output hold-off and one full drain.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int ROWS      = lbva_pkg::GRID_ROWS_DEF;
   localparam int COLS      = lbva_pkg::GRID_COLS_DEF;
   localparam int SLICES    = lbva_pkg::HEIGHT_SLICES_DEF;
   localparam int CNT_W     = lbva_pkg::COUNT_BITS_DEF;
   localparam int XY_MIN    = lbva_pkg::XY_MIN_MM;
   localparam int XY_STEP   = lbva_pkg::XY_STEP_MM;
   localparam int Z_MIN     = lbva_pkg::Z_MIN_MM;
   localparam int Z_STEP    = lbva_pkg::Z_STEP_MM;
   localparam int REQ_W     = 104;
   localparam int RSP_W     = 136;
   localparam int N_RANDOM  = 2000;
   localparam int IDLE_LIMIT = 300000;   // covers the clearing sweep after reset
   localparam int LONG_HOLD = 400;

   typedef struct {
      logic              accepted;
      logic [8:0]        hit_row;
      logic [8:0]        hit_col;
      logic [SLICES-1:0] occupancy;
      logic [15:0]       mean_int;
      logic [15:0]       mean_elo;
      logic [CNT_W-1:0]  point_count;
   } voxel_rsp_type;

   typedef struct {
      lbva_pkg::action_type act;
      logic [17:0] x, y;
      logic [13:0] z;
      logic [15:0] inten, elo;
      logic [8:0]  row, col;
   } voxel_req_type;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_tvalid = 0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic [lbva_pkg::ACT_W-1:0] req_tuser = lbva_pkg::ACT_NONE;
   logic             rsp_tvalid;
   logic             rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;

   lidar_bev_voxel_accumulator_core i_dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   always #4 clock = ~clock;

   // grid shadow
   bit [SLICES-1:0]  occ_grid [ROWS*COLS];
   bit [15+CNT_W:0]  isum_grid[ROWS*COLS];
   bit [15+CNT_W:0]  esum_grid[ROWS*COLS];
   bit [CNT_W-1:0]   cnt_grid [ROWS*COLS];

   voxel_rsp_type pending_rsp[$];
   int         mismatches = 0;
   bit         idle_on = 1;
   bit         long_hold = 0;
   bit         timed_out = 0;

   function automatic voxel_rsp_type cell_report(int r, int c);
      voxel_rsp_type o;
      int idx = r * COLS + c;
      o = '{default: '0};
      o.hit_row     = 9'(r);
      o.hit_col     = 9'(c);
      o.occupancy   = occ_grid[idx];
      o.point_count = cnt_grid[idx];
      if (cnt_grid[idx] != 0) begin
         o.mean_int = 16'(isum_grid[idx] / cnt_grid[idx]);
         o.mean_elo = 16'(esum_grid[idx] / cnt_grid[idx]);
      end
      return o;
   endfunction

   function automatic voxel_rsp_type grid_update(voxel_req_type q);
      voxel_rsp_type o;
      int x, y, z, r, c, s, idx;
      o = '{default: '0};
      case (q.act)
         lbva_pkg::ACT_ADD: begin
            x = int'(signed'(q.x));
            y = int'(signed'(q.y));
            z = int'(signed'(q.z));
            if (x > XY_MIN && x < XY_MIN + COLS*XY_STEP &&
                y > XY_MIN && y < XY_MIN + ROWS*XY_STEP &&
                z > Z_MIN && z < Z_MIN + SLICES*Z_STEP) begin
               c = (x - XY_MIN) / XY_STEP;
               r = (y - XY_MIN) / XY_STEP;
               s = (z - Z_MIN) / Z_STEP;
               idx = r * COLS + c;
               if (cnt_grid[idx] != {CNT_W{1'b1}}) begin
                  occ_grid[idx][s] = 1'b1;
                  isum_grid[idx] += (16+CNT_W)'(q.inten);
                  esum_grid[idx] += (16+CNT_W)'(q.elo);
                  cnt_grid[idx]  += CNT_W'(1);
                  o = cell_report(r, c);
                  o.accepted = 1'b1;
               end else begin
                  o = cell_report(r, c);
               end
            end
         end
         lbva_pkg::ACT_READ, lbva_pkg::ACT_READ_CLEAR: begin
            o.hit_row = q.row;
            o.hit_col = q.col;
            if (q.row < ROWS && q.col < COLS) begin
               o = cell_report(q.row, q.col);
               if (q.act == lbva_pkg::ACT_READ_CLEAR) begin
                  idx = q.row * COLS + q.col;
                  occ_grid[idx] = '0; isum_grid[idx] = '0;
                  esum_grid[idx] = '0; cnt_grid[idx] = '0;
               end
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // ---------------------------------------------------------------- sender
   // called at a falling edge; returns at the falling edge after acceptance
   task automatic push_point(voxel_req_type q, bit pinned, voxel_rsp_type pinned_rsp);
      int gap;
      voxel_rsp_type p;
      gap = idle_on ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= q.act;
      req_tdata  <= {4'b0, q.col, q.row, q.elo, q.inten, q.z, q.y, q.x};
      do @(posedge clock); while (!req_tready);
      p = grid_update(q);
      pending_rsp.push_back(pinned ? pinned_rsp : p);
      @(negedge clock);
   endtask

   function automatic voxel_req_type make_req(lbva_pkg::action_type a, int x, int y,
                                              int z, int inten, int elo, int r, int c);
      voxel_req_type q;
      q.act = a; q.x = 18'(x); q.y = 18'(y); q.z = 14'(z);
      q.inten = 16'(inten); q.elo = 16'(elo); q.row = 9'(r); q.col = 9'(c);
      return q;
   endfunction

   function automatic voxel_req_type random_req();
      voxel_req_type q;
      int pick, r, c;
      pick = $urandom_range(0, 99);
      r = $urandom_range(0, 5) * 59;           // a few hot cells incl. edges
      c = $urandom_range(0, 5) * 59 + (r == 295 ? 4 : 0);
      if (c > COLS - 1) c = COLS - 1;
      q.act   = lbva_pkg::ACT_ADD;
      q.inten = 16'($urandom);
      q.elo   = 16'($urandom);
      q.row   = 9'($urandom);
      q.col   = 9'($urandom);
      q.x = 18'(XY_MIN + c*XY_STEP + int'($urandom_range(0, 499)));
      q.y = 18'(XY_MIN + r*XY_STEP + int'($urandom_range(0, 499)));
      q.z = 14'(Z_MIN + int'($urandom_range(0, SLICES*Z_STEP)));
      if (pick < 8) begin                      // anywhere, mostly outside
         q.x = 18'($urandom); q.y = 18'($urandom); q.z = 14'($urandom);
      end else if (pick < 80) begin
      end else if (pick < 90) begin
         q.act = lbva_pkg::ACT_READ; q.row = 9'(r); q.col = 9'(c);
      end else if (pick < 96) begin
         q.act = lbva_pkg::ACT_READ_CLEAR; q.row = 9'(r); q.col = 9'(c);
      end else begin
         q.act = lbva_pkg::action_type'($urandom_range(1, 3));
      end
      return q;
   endfunction

   initial begin : stimulus
      voxel_req_type dir_req[$];
      bit         dir_pinned[$];
      voxel_rsp_type dir_rsp[$];
      voxel_rsp_type z0, e;
      z0 = '{default: '0};

      // directed table: pinned rows carry a hand-written response
      dir_req.push_back(make_req(lbva_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0));
      dir_pinned.push_back(1); dir_rsp.push_back(z0);
      dir_req.push_back(make_req(lbva_pkg::ACT_ADD, -75000, 0, 0, 1, 1, 0, 0));
      dir_pinned.push_back(1); dir_rsp.push_back(z0);
      dir_req.push_back(make_req(lbva_pkg::ACT_ADD, 0, 75000, 0, 1, 1, 0, 0));
      dir_pinned.push_back(1); dir_rsp.push_back(z0);
      dir_req.push_back(make_req(lbva_pkg::ACT_ADD, 0, 0, 4000, 1, 1, 0, 0));
      dir_pinned.push_back(1); dir_rsp.push_back(z0);
      dir_req.push_back(make_req(lbva_pkg::ACT_ADD, 0, 0, -2000, 1, 1, 0, 0));
      dir_pinned.push_back(1); dir_rsp.push_back(z0);
      dir_req.push_back(make_req(lbva_pkg::ACT_ADD, 131071, -131072, 8191, 1, 1, 511, 511));
      dir_pinned.push_back(1); dir_rsp.push_back(z0);
      dir_req.push_back(make_req(lbva_pkg::ACT_ADD, -131072, 131071, -8192, 1, 1, 0, 0));
      dir_pinned.push_back(1); dir_rsp.push_back(z0);
      dir_req.push_back(make_req(lbva_pkg::ACT_NONE, 1, 1, 1, 65535, 65535, 3, 3));
      dir_pinned.push_back(1); dir_rsp.push_back(z0);
      e = z0; e.hit_row = 9'd300; e.hit_col = 9'd511;
      dir_req.push_back(make_req(lbva_pkg::ACT_READ, 0, 0, 0, 0, 0, 300, 511));
      dir_pinned.push_back(1); dir_rsp.push_back(e);
      e = z0; e.hit_row = 9'd511; e.hit_col = 9'd0;
      dir_req.push_back(make_req(lbva_pkg::ACT_READ_CLEAR, 0, 0, 0, 0, 0, 511, 0));
      dir_pinned.push_back(1); dir_rsp.push_back(e);
      // corner cells, lowest and highest slice, extreme values
      dir_req.push_back(make_req(lbva_pkg::ACT_ADD, -74999, -74999, -1999, 65535, 0, 0, 0));
      dir_req.push_back(make_req(lbva_pkg::ACT_ADD, -74501, -74501, 3999, 0, 65535, 0, 0));
      dir_req.push_back(make_req(lbva_pkg::ACT_ADD, -74600, -74900, 1950, 65535, 65535, 0, 0));
      dir_req.push_back(make_req(lbva_pkg::ACT_ADD, 74999, 74999, 3999, 65535, 65535, 0, 0));
      dir_req.push_back(make_req(lbva_pkg::ACT_ADD, 74500, 74500, -1999, 1, 2, 0, 0));
      dir_req.push_back(make_req(lbva_pkg::ACT_ADD, 74999, -74999, 0, 12345, 54321, 0, 0));
      dir_req.push_back(make_req(lbva_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0));
      dir_req.push_back(make_req(lbva_pkg::ACT_READ, 0, 0, 0, 0, 0, 299, 299));
      dir_req.push_back(make_req(lbva_pkg::ACT_READ_CLEAR, 0, 0, 0, 0, 0, 0, 0));
      dir_req.push_back(make_req(lbva_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0));
      dir_req.push_back(make_req(lbva_pkg::ACT_READ_CLEAR, 0, 0, 0, 0, 0, 0, 299));
      dir_req.push_back(make_req(lbva_pkg::ACT_READ, 0, 0, 0, 0, 0, 299, 300));
      while (dir_pinned.size() < dir_req.size()) begin
         dir_pinned.push_back(0); dir_rsp.push_back(z0);
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_req[i]) push_point(dir_req[i], dir_pinned[i], dir_rsp[i]);

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n % 300 == 0) idle_on = ($urandom_range(0, 3) != 0);
         if (n == 600) long_hold = 1;   // output backs up, input keeps offering
         if (n == 600 || n == 601) idle_on = 0;
         if (n == 1200) begin
            req_tvalid <= 1'b0;
            wait (pending_rsp.size() == 0);
            @(negedge clock);
         end
         push_point(random_req(), 0, z0);
      end
      req_tvalid <= 1'b0;

      wait (pending_rsp.size() == 0);
      repeat (50) @(posedge clock);
      if (mismatches == 0)
         $display("lidar_bev_voxel_accumulator_core verification clean");
      else
         $display("lidar_bev_voxel_accumulator_core verification failed");
      $finish;
   end

   // -------------------------------------------------------------- receiver
   initial begin : receiver
      int w;
      voxel_rsp_type got, want;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            w = LONG_HOLD;
            long_hold = 0;
         end else begin
            w = idle_on ? $urandom_range(0, 17) : 0;
         end
         if (w > 0) begin
            rsp_tready <= 1'b0;
            repeat (w) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         {got.point_count, got.mean_elo, got.mean_int, got.occupancy,
          got.hit_col, got.hit_row, got.accepted} = rsp_tdata[130:0];
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response transaction %p", got);
         end else begin
            want = pending_rsp.pop_front();
            if (got.accepted !== want.accepted || got.hit_row !== want.hit_row ||
                got.hit_col !== want.hit_col || got.occupancy !== want.occupancy ||
                got.mean_int !== want.mean_int || got.mean_elo !== want.mean_elo ||
                got.point_count !== want.point_count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response mismatch\n  exp %p\n  got %p", want, got);
            end
         end
         @(negedge clock);
      end
   end

   // -------------------------------------------------------------- watchdog
   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
         if (quiet >= IDLE_LIMIT) begin
            $display("lidar_bev_voxel_accumulator_core verification failed");
            $finish;
         end
      end
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/lbva_pkg.sv
hw/rtl/lbva_ctrl.sv
hw/rtl/lbva_datapath.sv
hw/rtl/lidar_bev_voxel_accumulator_core.sv
tb/tb_top.sv
